[rtl/stq_pkg.sv]
// Shared types and codes for the sorted task priority queue.
// Holds the request and response beats, the queue entry layout and the
// command and status groups between the controller and the datapath.
package stq_pkg;

    localparam int OCC_W = 6;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_FOUND     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic               command;
        logic signed [7:0]  task_priority;
        logic        [31:0] task_time;
        logic        [14:0] task_id;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic        [31:0] found_time;
        logic signed [7:0]  found_priority;
        logic [OCC_W-1:0]   occupancy;
    } rsp_t;

    typedef struct packed {
        logic signed [7:0]  prio;
        logic        [31:0] time_ms;
        logic        [14:0] id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Datapath actions issued by the controller.
    typedef struct packed {
        logic    load;
        logic    rd_last;
        logic    rd_first;
        logic    shift;
        logic    put_above;
        logic    put_zero;
        logic    step;
        logic    res_load;
        status_t res_status;
        logic    push;
    } ctrl_cmd_t;

    // Conditions reported back by the datapath.
    typedef struct packed {
        logic is_insert;
        logic full;
        logic empty;
        logic goes_first;
        logic hit;
        logic idx_zero;
        logic idx_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

[rtl/stq_ram.sv]
// Generic single write port, single read port RAM with registered read.
// Stand-alone; no package dependency.
module stq_ram #(
    parameter int WIDTH = 55,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/stq_datapath.sv]
// Datapath of the sorted task priority queue: entry RAM, scan index,
// fill count, key comparator, result and output registers.
// Depends on stq_pkg and stq_ram.
module stq_datapath #(
    parameter int DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  stq_pkg::req_t      req,
    input  stq_pkg::ctrl_cmd_t cmd,
    output stq_pkg::ctrl_sts_t sts,
    input  logic               rsp_stall,
    output logic               rsp_valid,
    output stq_pkg::rsp_t      rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // True when key a must be served before key b.
    function automatic logic goes_before(input stq_pkg::entry_t a, input stq_pkg::entry_t b);
        logic result;
        if (a.prio != b.prio)
        begin
            result = a.prio > b.prio;
        end
        else if (a.time_ms != b.time_ms)
        begin
            result = a.time_ms < b.time_ms;
        end
        else
        begin
            result = a.id < b.id;
        end
        return result;
    endfunction

    stq_pkg::req_t   item_reg;
    stq_pkg::rsp_t   res_reg;
    stq_pkg::rsp_t   res_next;
    stq_pkg::rsp_t   rsp_reg;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [IDX_W-1:0]             ram_raddr;
    stq_pkg::entry_t              ram_wdata;
    logic [stq_pkg::ENTRY_W-1:0]  ram_rdata;
    stq_pkg::entry_t              rd_entry;
    stq_pkg::entry_t              new_entry;

    assign rd_entry = stq_pkg::entry_t'(ram_rdata);

    assign new_entry.prio    = item_reg.task_priority;
    assign new_entry.time_ms = item_reg.task_time;
    assign new_entry.id      = item_reg.task_id;

    stq_ram #(
        .WIDTH (stq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The insert scan walks down from the tail: each cycle the entry read in
    // the previous cycle is either moved up one place, while the next lower
    // entry is being read, or the new task lands just above it.
    always_comb
    begin
        idx_next   = idx_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = new_entry;
        ram_raddr  = '0;
        if (cmd.rd_last)
        begin
            ram_raddr = IDX_W'(count_reg - CNT_W'(1));
            idx_next  = IDX_W'(count_reg - CNT_W'(1));
        end
        if (cmd.rd_first)
        begin
            ram_raddr = '0;
            idx_next  = '0;
        end
        if (cmd.shift)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg + IDX_W'(1);
            ram_wdata = rd_entry;
            ram_raddr = idx_reg - IDX_W'(1);
            idx_next  = idx_reg - IDX_W'(1);
        end
        if (cmd.put_above)
        begin
            ram_we     = 1'b1;
            ram_waddr  = idx_reg + IDX_W'(1);
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.put_zero)
        begin
            ram_we     = 1'b1;
            ram_waddr  = '0;
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.step)
        begin
            ram_raddr = idx_reg + IDX_W'(1);
            idx_next  = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        res_next.status    = cmd.res_status;
        res_next.occupancy = stq_pkg::OCC_W'(count_next);
        if (cmd.res_status == stq_pkg::STATUS_FOUND)
        begin
            res_next.found_time     = rd_entry.time_ms;
            res_next.found_priority = rd_entry.prio;
        end
        else
        begin
            res_next.found_time     = '0;
            res_next.found_priority = '0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.push)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
        if (cmd.push)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign sts.is_insert  = (item_reg.command == stq_pkg::CMD_INSERT);
    assign sts.full       = (count_reg == CNT_W'(DEPTH));
    assign sts.empty      = (count_reg == '0);
    assign sts.goes_first = goes_before(new_entry, rd_entry);
    assign sts.hit        = (rd_entry.id == item_reg.task_id);
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.idx_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/stq_ctrl.sv]
// Controller of the sorted task priority queue: sequences the insert and
// lookup scans and the hand-over of each result to the output register.
// Depends on stq_pkg.
module stq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  stq_pkg::ctrl_sts_t sts,
    output stq_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_INS      = 6'b000100,
        S_PUT0     = 6'b001000,
        S_LKP      = 6'b010000,
        S_REPLY    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_status = stq_pkg::STATUS_INSERTED;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.is_insert)
                begin
                    if (sts.full)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = stq_pkg::STATUS_FULL;
                        state_next     = S_REPLY;
                    end
                    else if (sts.empty)
                    begin
                        cmd.put_zero   = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = stq_pkg::STATUS_INSERTED;
                        state_next     = S_REPLY;
                    end
                    else
                    begin
                        cmd.rd_last = 1'b1;
                        state_next  = S_INS;
                    end
                end
                else if (sts.empty)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = stq_pkg::STATUS_NOT_FOUND;
                    state_next     = S_REPLY;
                end
                else
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_LKP;
                end
            end
            S_INS:
            begin
                if (sts.goes_first)
                begin
                    cmd.shift = 1'b1;
                    if (sts.idx_zero)
                    begin
                        state_next = S_PUT0;
                    end
                end
                else
                begin
                    cmd.put_above  = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = stq_pkg::STATUS_INSERTED;
                    state_next     = S_REPLY;
                end
            end
            S_PUT0:
            begin
                cmd.put_zero   = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = stq_pkg::STATUS_INSERTED;
                state_next     = S_REPLY;
            end
            S_LKP:
            begin
                if (sts.hit)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = stq_pkg::STATUS_FOUND;
                    state_next     = S_REPLY;
                end
                else if (sts.idx_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = stq_pkg::STATUS_NOT_FOUND;
                    state_next     = S_REPLY;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_REPLY:
            begin
                // Wait here until the output register can take the beat.
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

[rtl/sorted_task_priority_queue.sv]
// Sorted task priority queue: a bounded queue of up to QUEUE_DEPTH tasks
// kept in service order (higher priority, then shorter time, then lower id).
// Depends on stq_pkg, stq_ctrl and stq_datapath.
//
// One command is taken at a time and each gives exactly one response beat.
// The entries sit in a single-port-write, registered-read RAM, so every
// scan step costs one RAM read. An insert scans down from the tail and
// moves up one place each queued task that must follow the new one (0 to
// the fill count of them); an insert into an empty or full queue makes no
// scan. A lookup scans up from position zero to the first matching id, or
// through the whole queue when nothing matches, and makes no scan on an
// empty queue. The next command is accepted once its predecessor's
// response has moved into the output register, even while that response
// still waits to be taken. No clearing pass is needed after reset.
module sorted_task_priority_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  stq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output stq_pkg::rsp_t rsp
);

    stq_pkg::ctrl_cmd_t cmd;
    stq_pkg::ctrl_sts_t sts;

    stq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    stq_datapath #(
        .DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
